[rtl/isn_pkg.sv]
// Shared types and constants for the IQ sample normalizer.
// Used by the lane, the merge stage and the top level.
`timescale 1ns / 1ps

package isn_pkg;

   // Fixed-point format of the results.
   localparam int FRAC_BITS = 30;
   localparam int OUT_W     = 32;

   // Integer path: sum of shifted copies of the magnitude, GUARD_BITS below the point.
   localparam int GUARD_BITS  = 67;
   localparam int TERM_SHIFT  = FRAC_BITS + GUARD_BITS;
   localparam int SUM_W       = 31 + GUARD_BITS;
   localparam int WIDE_W      = 64 + TERM_SHIFT;
   localparam int TERMS       = 6;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (GUARD_BITS - 1);

   // Float path.
   localparam int MAG_W          = 54;
   localparam int DBL_EXP_OFFSET = 1023 + 52 - FRAC_BITS;
   localparam int SGL_EXP_OFFSET = 127 + 23 - FRAC_BITS;
   localparam int OVF_SHIFT      = 33;

   // Sample kinds.
   localparam logic [1:0] KIND_IEEE     = 2'd0;
   localparam logic [1:0] KIND_TWOS     = 2'd1;
   localparam logic [1:0] KIND_OFFSET   = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   // Component width codes.
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   // Register indexes.
   localparam logic [1:0] CSR_SAMPLE_KIND = 2'd0;
   localparam logic [1:0] CSR_WIDTH_CODE  = 2'd1;
   localparam logic [1:0] CSR_BIG_ENDIAN  = 2'd2;

   typedef enum logic [1:0] {
      OVR_NONE,
      OVR_ZERO,
      OVR_SAT
   } override_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] wcode;
      logic       big_endian;
   } cfg_type;

   // Load enables for the four lane pipeline registers.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } pipe_ctrl_type;

endpackage

[rtl/isn_req_if.sv]
// Input channel of the IQ sample normalizer: valid/ready with the raw sample words.
// Stands alone; no package needed.
`timescale 1ns / 1ps

interface isn_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] i_raw;
   logic [63:0] q_raw;
   logic        block_end;

   modport source (output valid, i_raw, q_raw, block_end, input ready);
   modport sink   (input valid, i_raw, q_raw, block_end, output ready);
endinterface

[rtl/isn_rsp_if.sv]
// Result channel of the IQ sample normalizer: valid/ready with the fixed-point values.
// Stands alone; no package needed.
`timescale 1ns / 1ps

interface isn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] i_value;
   logic signed [31:0] q_value;
   logic               range_flag;
   logic               block_end_out;

   modport source (output valid, i_value, q_value, range_flag, block_end_out, input ready);
   modport sink   (input valid, i_value, q_value, range_flag, block_end_out, output ready);
endinterface

[rtl/isn_lane.sv]
// One conversion lane: raw component word to fixed point, four register stages.
// Depends on isn_pkg.
`timescale 1ns / 1ps

module isn_lane (
   input  logic                  clock,
   input  isn_pkg::cfg_type      cfg,
   input  isn_pkg::pipe_ctrl_type ctrl,
   input  logic [63:0]           raw,
   output logic [31:0]           value,
   output logic                  flag
);

   // ---------------- stage 0: byte order, decode ----------------
   logic [63:0] word, mask, half, u, mag_int;
   logic        msb, neg_int;
   logic        sgn, ex_max, ex_min, frac_nz;
   logic [10:0] ex_eff;
   logic [52:0] m_val;
   logic signed [11:0] shift_s;
   isn_pkg::override_type ovr0;
   logic        neg0, is_float0;

   always_comb begin
      word = raw;
      if (cfg.big_endian) begin
         case (cfg.wcode)
            isn_pkg::WIDTH_16: word = {48'd0, raw[7:0], raw[15:8]};
            isn_pkg::WIDTH_32: word = {32'd0, raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            isn_pkg::WIDTH_64: word = {raw[7:0], raw[15:8], raw[23:16], raw[31:24],
                                       raw[39:32], raw[47:40], raw[55:48], raw[63:56]};
            default:           word = raw;
         endcase
      end
   end

   always_comb begin
      case (cfg.wcode)
         isn_pkg::WIDTH_8: begin
            mask = 64'h0000_0000_0000_00FF;
            half = 64'h0000_0000_0000_0080;
         end
         isn_pkg::WIDTH_16: begin
            mask = 64'h0000_0000_0000_FFFF;
            half = 64'h0000_0000_0000_8000;
         end
         isn_pkg::WIDTH_32: begin
            mask = 64'h0000_0000_FFFF_FFFF;
            half = 64'h0000_0000_8000_0000;
         end
         default: begin
            mask = 64'hFFFF_FFFF_FFFF_FFFF;
            half = 64'h8000_0000_0000_0000;
         end
      endcase
      u   = word & mask;
      msb = |(u & half);
      if (cfg.kind == isn_pkg::KIND_OFFSET) begin
         neg_int = !msb;
         mag_int = msb ? (u ^ half) : (half - u);
      end else begin
         neg_int = msb;
         mag_int = msb ? ((~u + 64'd1) & mask) : u;
      end
   end

   always_comb begin
      if (cfg.wcode == isn_pkg::WIDTH_64) begin
         sgn     = word[63];
         ex_max  = &word[62:52];
         ex_min  = ~|word[62:52];
         frac_nz = |word[51:0];
         m_val   = {!ex_min, word[51:0]};
         ex_eff  = ex_min ? 11'd1 : word[62:52];
         shift_s = $signed({1'b0, ex_eff}) - 12'(isn_pkg::DBL_EXP_OFFSET);
      end else begin
         sgn     = word[31];
         ex_max  = &word[30:23];
         ex_min  = ~|word[30:23];
         frac_nz = |word[22:0];
         m_val   = {29'd0, !ex_min, word[22:0]};
         ex_eff  = ex_min ? 11'd1 : {3'd0, word[30:23]};
         shift_s = $signed({1'b0, ex_eff}) - 12'(isn_pkg::SGL_EXP_OFFSET);
      end
   end

   always_comb begin
      ovr0      = isn_pkg::OVR_NONE;
      neg0      = neg_int;
      is_float0 = 1'b0;
      case (cfg.kind)
         isn_pkg::KIND_IEEE: begin
            is_float0 = 1'b1;
            neg0      = sgn;
            if (cfg.wcode == isn_pkg::WIDTH_8 || cfg.wcode == isn_pkg::WIDTH_16) begin
               ovr0 = isn_pkg::OVR_ZERO;
            end else if (ex_max) begin
               // Infinity saturates, NaN reads as zero.
               ovr0 = frac_nz ? isn_pkg::OVR_ZERO : isn_pkg::OVR_SAT;
            end
         end
         isn_pkg::KIND_TWOS, isn_pkg::KIND_OFFSET: ovr0 = isn_pkg::OVR_NONE;
         default: ovr0 = isn_pkg::OVR_ZERO;
      endcase
   end

   logic [63:0]           r1_mag_ff;
   logic [52:0]           r1_m_ff;
   logic signed [11:0]    r1_shift_ff;
   logic [1:0]            r1_wcode_ff;
   isn_pkg::override_type r1_ovr_ff;
   logic                  r1_neg_ff, r1_float_ff;

   always_ff @(posedge clock) begin
      if (ctrl.ld1) begin
         r1_mag_ff   <= mag_int;
         r1_m_ff     <= m_val;
         r1_shift_ff <= shift_s;
         r1_wcode_ff <= cfg.wcode;
         r1_ovr_ff   <= ovr0;
         r1_neg_ff   <= neg0;
         r1_float_ff <= is_float0;
      end
   end

   // ---------------- stage 1: terms of the reciprocal series, float shift ----------------
   // x / (2^m - 1) is the sum of x * 2^(-k*m) over k; six terms reach the guard precision.
   logic [isn_pkg::WIDE_W-1:0] wide;
   logic [isn_pkg::SUM_W-1:0]  term [isn_pkg::TERMS];
   logic [isn_pkg::SUM_W-1:0]  p1, p2, p3;

   assign wide = {r1_mag_ff, isn_pkg::TERM_SHIFT'(0)};

   for (genvar k = 0; k < isn_pkg::TERMS; k++) begin : g_term
      always_comb begin
         case (r1_wcode_ff)
            isn_pkg::WIDTH_8:  term[k] = isn_pkg::SUM_W'(wide >> (7 * (k + 1)));
            isn_pkg::WIDTH_16: term[k] = isn_pkg::SUM_W'(wide >> (15 * (k + 1)));
            isn_pkg::WIDTH_32: term[k] = isn_pkg::SUM_W'(wide >> (31 * (k + 1)));
            default:           term[k] = isn_pkg::SUM_W'(wide >> (63 * (k + 1)));
         endcase
      end
   end

   assign p1 = term[0] + term[1];
   assign p2 = term[2] + term[3];
   assign p3 = term[4] + term[5] + isn_pkg::ROUND_HALF;

   logic [11:0]               rshift;
   logic [85:0]               shl;
   logic [63:0]               shr;
   logic [isn_pkg::MAG_W-1:0] fmag1;
   logic                      ovf1;
   isn_pkg::override_type     ovr1;

   always_comb begin
      rshift = 12'd0 - r1_shift_ff;
      shl    = {33'd0, r1_m_ff} << r1_shift_ff[5:0];
      shr    = {11'd0, r1_m_ff} >> (rshift[5:0] - 6'd1);
      ovf1   = 1'b0;
      fmag1  = '0;
      if (!r1_shift_ff[11]) begin
         if (r1_shift_ff > 12'(isn_pkg::OVF_SHIFT)) begin
            ovf1 = |r1_m_ff;
         end else begin
            ovf1  = |shl[85:isn_pkg::OVF_SHIFT];
            fmag1 = isn_pkg::MAG_W'(shl[isn_pkg::OVF_SHIFT-1:0]);
         end
      end else if (~|rshift[11:6]) begin
         // Round half away from zero on the magnitude.
         fmag1 = {1'b0, shr[53:1]} + isn_pkg::MAG_W'(shr[0]);
      end
      ovr1 = r1_ovr_ff;
      if (r1_ovr_ff == isn_pkg::OVR_NONE && r1_float_ff && ovf1) begin
         ovr1 = isn_pkg::OVR_SAT;
      end
   end

   logic [isn_pkg::SUM_W-1:0] r2_p1_ff, r2_p2_ff, r2_p3_ff;
   logic [isn_pkg::MAG_W-1:0] r2_fmag_ff;
   isn_pkg::override_type     r2_ovr_ff;
   logic                      r2_neg_ff, r2_float_ff;

   always_ff @(posedge clock) begin
      if (ctrl.ld2) begin
         r2_p1_ff    <= p1;
         r2_p2_ff    <= p2;
         r2_p3_ff    <= p3;
         r2_fmag_ff  <= fmag1;
         r2_ovr_ff   <= ovr1;
         r2_neg_ff   <= r1_neg_ff;
         r2_float_ff <= r1_float_ff;
      end
   end

   // ---------------- stage 2: first partial sum ----------------
   logic [isn_pkg::SUM_W-1:0] r3_sum_ff, r3_p3_ff;
   logic [isn_pkg::MAG_W-1:0] r3_fmag_ff;
   isn_pkg::override_type     r3_ovr_ff;
   logic                      r3_neg_ff, r3_float_ff;

   always_ff @(posedge clock) begin
      if (ctrl.ld3) begin
         r3_sum_ff   <= r2_p1_ff + r2_p2_ff;
         r3_p3_ff    <= r2_p3_ff;
         r3_fmag_ff  <= r2_fmag_ff;
         r3_ovr_ff   <= r2_ovr_ff;
         r3_neg_ff   <= r2_neg_ff;
         r3_float_ff <= r2_float_ff;
      end
   end

   // ---------------- stage 3: final sum, rounded quotient ----------------
   logic [isn_pkg::SUM_W-1:0] total;
   logic [isn_pkg::MAG_W-1:0] mag3;

   assign total = r3_sum_ff + r3_p3_ff;
   assign mag3  = r3_float_ff ? r3_fmag_ff
                              : isn_pkg::MAG_W'(total[isn_pkg::SUM_W-1:isn_pkg::GUARD_BITS]);

   logic [isn_pkg::MAG_W-1:0] r4_mag_ff;
   isn_pkg::override_type     r4_ovr_ff;
   logic                      r4_neg_ff;

   always_ff @(posedge clock) begin
      if (ctrl.ld4) begin
         r4_mag_ff <= mag3;
         r4_ovr_ff <= r3_ovr_ff;
         r4_neg_ff <= r3_neg_ff;
      end
   end

   // ---------------- stage 4: clamp and sign ----------------
   always_comb begin
      value = 32'd0;
      flag  = 1'b1;
      case (r4_ovr_ff)
         isn_pkg::OVR_NONE: begin
            flag = 1'b0;
            if (r4_neg_ff) begin
               if (r4_mag_ff > isn_pkg::MAG_W'(64'h8000_0000)) begin
                  value = 32'h8000_0000;
                  flag  = 1'b1;
               end else begin
                  value = 32'd0 - r4_mag_ff[31:0];
               end
            end else if (r4_mag_ff > isn_pkg::MAG_W'(64'h7FFF_FFFF)) begin
               value = 32'h7FFF_FFFF;
               flag  = 1'b1;
            end else begin
               value = r4_mag_ff[31:0];
            end
         end
         isn_pkg::OVR_SAT: value = r4_neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
         isn_pkg::OVR_ZERO: value = 32'd0;
         default: value = 32'd0;
      endcase
   end

endmodule

[rtl/isn_merge.sv]
// Merge stage: joins the two lane results and flags into the registered result channel.
// Depends on isn_pkg and isn_rsp_if.
`timescale 1ns / 1ps

module isn_merge (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] i_value,
   input  logic [31:0] q_value,
   input  logic        i_flag,
   input  logic        q_flag,
   input  logic        block_end,
   output logic        load,
   isn_rsp_if.source   rsp_chan
);

   logic                       valid_ff, valid_in;
   logic [isn_pkg::OUT_W-1:0]  i_ff, q_ff;
   logic                       flag_ff, end_ff;

   assign load     = !valid_ff || rsp_chan.ready;
   assign valid_in = load ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         i_ff    <= i_value;
         q_ff    <= q_value;
         flag_ff <= i_flag | q_flag;
         end_ff  <= block_end;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.i_value       = i_ff;
   assign rsp_chan.q_value       = q_ff;
   assign rsp_chan.range_flag    = flag_ff;
   assign rsp_chan.block_end_out = end_ff;

endmodule

[rtl/iq_sample_normalizer.sv]
// Top level of the IQ sample normalizer: configuration registers, pipeline control,
// two conversion lanes and the merge stage. Depends on isn_pkg, the channel interfaces,
// isn_lane and isn_merge.
`timescale 1ns / 1ps

// The block takes one complex sample per clock cycle unless the response side stalls,
// and returns one result per sample, in order. A request passes through the four lane
// registers and then the merge register; the I and Q components run in two identical
// lanes of four register stages each (byte reorder and decode, reciprocal series terms
// and float shift, two adder stages), with the clamp after the last. The request side
// stays ready as long as some stage can move, so a result waiting on the response side
// holds up new samples only once every stage is full. Configuration is to be written
// through the csr port only when no sample is in flight; the block does not enforce this.
module iq_sample_normalizer (
   input  logic       clock,
   input  logic       reset,
   isn_req_if.sink    req_chan,
   isn_rsp_if.source  rsp_chan,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [1:0] csr_data
);

   isn_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            isn_pkg::CSR_SAMPLE_KIND: cfg_in.kind       = csr_data;
            isn_pkg::CSR_WIDTH_CODE:  cfg_in.wcode      = csr_data;
            isn_pkg::CSR_BIG_ENDIAN:  cfg_in.big_endian = csr_data[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind       <= isn_pkg::KIND_TWOS;
         cfg_ff.wcode      <= isn_pkg::WIDTH_16;
         cfg_ff.big_endian <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage valid bits for the four lane registers, with block_end riding alongside.
   logic [3:0] stage_valid_ff, stage_valid_in;
   logic [3:0] stage_end_ff;
   logic       out_load;
   isn_pkg::pipe_ctrl_type ctrl;

   always_comb begin
      ctrl.ld4 = !stage_valid_ff[3] || out_load;
      ctrl.ld3 = !stage_valid_ff[2] || ctrl.ld4;
      ctrl.ld2 = !stage_valid_ff[1] || ctrl.ld3;
      ctrl.ld1 = !stage_valid_ff[0] || ctrl.ld2;
   end

   assign req_chan.ready = ctrl.ld1;

   always_comb begin
      stage_valid_in[0] = ctrl.ld1 ? req_chan.valid     : stage_valid_ff[0];
      stage_valid_in[1] = ctrl.ld2 ? stage_valid_ff[0]  : stage_valid_ff[1];
      stage_valid_in[2] = ctrl.ld3 ? stage_valid_ff[1]  : stage_valid_ff[2];
      stage_valid_in[3] = ctrl.ld4 ? stage_valid_ff[2]  : stage_valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 4'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld1) begin
         stage_end_ff[0] <= req_chan.block_end;
      end
      if (ctrl.ld2) begin
         stage_end_ff[1] <= stage_end_ff[0];
      end
      if (ctrl.ld3) begin
         stage_end_ff[2] <= stage_end_ff[1];
      end
      if (ctrl.ld4) begin
         stage_end_ff[3] <= stage_end_ff[2];
      end
   end

   logic [31:0] i_val, q_val;
   logic        i_flag, q_flag;

   isn_lane u_lane_i (
      .clock (clock),
      .cfg   (cfg_ff),
      .ctrl  (ctrl),
      .raw   (req_chan.i_raw),
      .value (i_val),
      .flag  (i_flag)
   );

   isn_lane u_lane_q (
      .clock (clock),
      .cfg   (cfg_ff),
      .ctrl  (ctrl),
      .raw   (req_chan.q_raw),
      .value (q_val),
      .flag  (q_flag)
   );

   isn_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid_ff[3]),
      .i_value   (i_val),
      .q_value   (q_val),
      .i_flag    (i_flag),
      .q_flag    (q_flag),
      .block_end (stage_end_ff[3]),
      .load      (out_load),
      .rsp_chan  (rsp_chan)
   );

   // Requests are refused only when the whole pipeline is full behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("request channel stalled without response backpressure");

   // A finished sample in the last lane stage moves into the result register.
   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[3] && out_load |=> rsp_chan.valid)
      else $error("sample lost between last lane stage and result register");

   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && stage_valid_ff == 4'd0)
      else $error("pipeline not empty after reset");

endmodule

[sim/tb_top.sv]
// Testbench for the IQ sample normalizer: directed and random samples over all formats.
// Depends on isn_pkg, isn_req_if, isn_rsp_if and iq_sample_normalizer.
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic [63:0] i_raw;
      logic [63:0] q_raw;
      logic        block_end;
   } sample_type;

   typedef struct {
      logic [31:0] i_value;
      logic [31:0] q_value;
      logic        range_flag;
      logic        block_end_out;
   } norm_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = isn_pkg::CSR_SAMPLE_KIND;
   logic [1:0] csr_data = 2'd0;

   isn_req_if req_chan ();
   isn_rsp_if rsp_chan ();

   iq_sample_normalizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   sample_type pending_samples[$];
   norm_type   expected_norms[$];
   logic [1:0] cur_kind = isn_pkg::KIND_TWOS;
   logic [1:0] cur_wcode = isn_pkg::WIDTH_16;
   logic       cur_be = 1'b0;
   int mismatches = 0;
   int cycles = 0;
   bit calm = 1'b0;
   bit hold_sender = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Clamp a sign and magnitude into the 32-bit output.
   function automatic logic [31:0] clamp_mag(input bit neg, input logic [63:0] mag,
                                             inout bit flag);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            flag = 1'b1;
            return 32'h8000_0000;
         end
         return 32'(-mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         flag = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function automatic logic [31:0] scale_integer(input logic [63:0] word, input int nbits,
                                                 input bit offset, inout bit flag);
      logic [63:0] mask, half, u, mag, dv;
      logic [127:0] num, quo, rem;
      bit neg;
      mask = (nbits == 64) ? '1 : ((64'd1 << nbits) - 1);
      half = 64'd1 << (nbits - 1);
      u = word & mask;
      dv = half - 1;
      if (offset) begin
         neg = u < half;
         mag = neg ? half - u : u - half;
      end else begin
         neg = (u & half) != 0;
         mag = neg ? ((~u + 1) & mask) : u;
      end
      num = 128'(mag) << isn_pkg::FRAC_BITS;
      quo = num / dv;
      rem = num % dv;
      if ((rem << 1) >= 128'(dv)) quo = quo + 1;
      if (quo > 128'h1_0000_0000) quo = 128'h1_0000_0000;
      return clamp_mag(neg, quo[63:0], flag);
   endfunction

   function automatic logic [31:0] scale_float(input logic [63:0] raw, input bit dbl,
                                               inout bit flag);
      int mbits, ebits, bias, e, s, len, k;
      logic [63:0] w, emax, ex, frac, m, mag;
      bit neg;
      mbits = dbl ? 52 : 23;
      ebits = dbl ? 11 : 8;
      bias = dbl ? 1023 : 127;
      w = dbl ? raw : {32'd0, raw[31:0]};
      neg = w[mbits + ebits];
      emax = (64'd1 << ebits) - 1;
      ex = (w >> mbits) & emax;
      frac = w & ((64'd1 << mbits) - 1);
      if (ex == emax) begin
         flag = 1'b1;
         if (frac != 0) return 32'd0;
         return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (ex == 0) begin
         m = frac;
         e = 1 - bias - mbits;
      end else begin
         m = frac | (64'd1 << mbits);
         e = int'(ex) - bias - mbits;
      end
      if (m == 0) return 32'd0;
      s = e + isn_pkg::FRAC_BITS;
      if (s >= 0) begin
         len = 0;
         while (len < 64 && (m >> len) != 0) len++;
         if (len + s > 33) begin
            flag = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         mag = m << s;
      end else begin
         k = -s;
         if (k >= 64) mag = 0;
         else begin
            mag = m >> k;
            if ((m & ((64'd1 << k) - 1)) >= (64'd1 << (k - 1))) mag = mag + 1;
         end
      end
      return clamp_mag(neg, mag, flag);
   endfunction

   function automatic logic [31:0] normalize_component(input logic [63:0] raw,
                                                       inout bit flag);
      int nbits;
      logic [63:0] w;
      nbits = 8 << cur_wcode;
      w = raw;
      if (cur_be && nbits > 8) begin
         w = '0;
         for (int k = 0; k < nbits / 8; k++) w[8*(nbits/8-1-k) +: 8] = raw[8*k +: 8];
      end
      case (cur_kind)
         isn_pkg::KIND_IEEE: begin
            if (nbits < 32) begin
               flag = 1'b1;
               return 32'd0;
            end
            return scale_float(w, nbits == 64, flag);
         end
         isn_pkg::KIND_TWOS: return scale_integer(w, nbits, 1'b0, flag);
         isn_pkg::KIND_OFFSET: return scale_integer(w, nbits, 1'b1, flag);
         default: begin
            flag = 1'b1;
            return 32'd0;
         end
      endcase
   endfunction

   function automatic norm_type predict_norm(input sample_type smp);
      norm_type r;
      bit flag;
      flag = 1'b0;
      r.i_value = normalize_component(smp.i_raw, flag);
      r.q_value = normalize_component(smp.q_raw, flag);
      r.range_flag = flag;
      r.block_end_out = smp.block_end;
      return r;
   endfunction

   // Driver: the prediction is made when the transaction is accepted. A sample leaves
   // the queue only once accepted, and a waiting transaction is held unchanged.
   always @(posedge clock) begin
      sample_type acc;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            acc.i_raw = req_chan.i_raw;
            acc.q_raw = req_chan.q_raw;
            acc.block_end = req_chan.block_end;
            expected_norms = {expected_norms, predict_norm(acc)};
            void'(pending_samples.pop_front());
         end
         if (req_chan.valid && !req_chan.ready) begin
            req_chan.valid <= 1'b1;
         end else if (pending_samples.size() > 0 && !hold_sender
                      && (calm || $urandom_range(99) >= 10)) begin
            req_chan.valid <= 1'b1;
            req_chan.i_raw <= pending_samples[0].i_raw;
            req_chan.q_raw <= pending_samples[0].q_raw;
            req_chan.block_end <= pending_samples[0].block_end;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // The response side idles at random as well.
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= calm || $urandom_range(99) >= 10;
   end

   always @(posedge clock) begin
      norm_type exp_r;
      cycles <= cycles + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_norms.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("Unexpected result transaction");
         end else begin
            exp_r = expected_norms.pop_front();
            if (rsp_chan.i_value !== exp_r.i_value || rsp_chan.q_value !== exp_r.q_value
                || rsp_chan.range_flag !== exp_r.range_flag
                || rsp_chan.block_end_out !== exp_r.block_end_out) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("Mismatch: expected i=%h q=%h f=%b e=%b, got i=%h q=%h f=%b e=%b",
                           exp_r.i_value, exp_r.q_value, exp_r.range_flag,
                           exp_r.block_end_out, rsp_chan.i_value, rsp_chan.q_value,
                           rsp_chan.range_flag, rsp_chan.block_end_out);
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_chan.valid || expected_norms.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         isn_pkg::CSR_SAMPLE_KIND: cur_kind = value;
         isn_pkg::CSR_WIDTH_CODE:  cur_wcode = value;
         default:                  cur_be = value[0];
      endcase
   endtask

   task automatic set_format(input logic [1:0] kind, input logic [1:0] wcode,
                             input logic be);
      wait_drained();
      write_reg(isn_pkg::CSR_SAMPLE_KIND, kind);
      write_reg(isn_pkg::CSR_WIDTH_CODE, wcode);
      write_reg(isn_pkg::CSR_BIG_ENDIAN, {1'b0, be});
      @(posedge clock);
   endtask

   task automatic add_sample(input logic [63:0] i_raw, input logic [63:0] q_raw);
      sample_type smp;
      smp.i_raw = i_raw;
      smp.q_raw = q_raw;
      smp.block_end = 1'($urandom_range(1));
      pending_samples = {pending_samples, smp};
   endtask

   // Raw words shaped for the float formats: exponents near the useful range most times.
   function automatic logic [63:0] random_word(input logic [1:0] wcode, input bit fp);
      logic [63:0] w;
      w = {$urandom, $urandom};
      if (fp && $urandom_range(3) != 0) begin
         if (wcode == isn_pkg::WIDTH_64) w[62:52] = 11'(1023 - 40 + $urandom_range(45));
         else w[30:23] = 8'(127 - 40 + $urandom_range(45));
      end
      return w;
   endfunction

   initial begin
      logic [1:0] kind, wcode;
      logic be;
      logic [63:0] a, b;
      req_chan.valid = 1'b0;
      req_chan.i_raw = '0;
      req_chan.q_raw = '0;
      req_chan.block_end = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset format (16-bit signed), extremes.
      add_sample(64'h0000, 64'h7FFF);
      add_sample(64'h8000, 64'h8001);
      add_sample(64'hFFFF_FFFF_FFFF_FFFF, 64'hABCD_0000_0000_0001);
      set_format(isn_pkg::KIND_OFFSET, isn_pkg::WIDTH_8, 1'b0);
      add_sample(64'h00, 64'hFF);
      add_sample(64'h80, 64'h7F);
      set_format(isn_pkg::KIND_TWOS, isn_pkg::WIDTH_64, 1'b1);
      add_sample(64'h0000_0000_0000_0080, 64'hFFFF_FFFF_FFFF_FF7F);
      add_sample(64'h0100_0000_0000_0000, 64'h0000_0000_0000_0000);
      set_format(isn_pkg::KIND_IEEE, isn_pkg::WIDTH_32, 1'b0);
      add_sample(64'h3F80_0000, 64'hBF80_0000);         // one and minus one
      add_sample(64'h4000_0000, 64'hC000_0000);         // two saturates, minus two fits
      add_sample(64'h7F80_0000, 64'hFF80_0000);         // infinities
      add_sample(64'h7FC0_0000, 64'h8000_0000);         // NaN and negative zero
      add_sample(64'h0000_0001, 64'h3080_0000);         // subnormal, one LSB
      set_format(isn_pkg::KIND_IEEE, isn_pkg::WIDTH_64, 1'b1);
      add_sample(64'h0000_0000_0000_F03F, 64'h0000_0000_0000_F0BF);
      add_sample(64'h0000_0000_0000_F87F, 64'h0000_0000_0000_F0FF);
      set_format(isn_pkg::KIND_IEEE, isn_pkg::WIDTH_16, 1'b0);
      add_sample(64'h3C00, 64'h0000);                   // narrow float is invalid
      set_format(isn_pkg::KIND_RESERVED, isn_pkg::WIDTH_32, 1'b0);
      add_sample(64'h1234_5678, 64'h0);                 // unused kind

      // Random phases; the sender is held once until all results are back.
      for (int ph = 0; ph < 26; ph++) begin
         kind = 2'($urandom_range(2));
         wcode = 2'($urandom_range(3));
         be = 1'($urandom_range(1));
         set_format(kind, wcode, be);
         calm = (ph == 5);
         if (ph == 10) begin
            for (int n = 0; n < 12; n++) add_sample(random_word(wcode, 1'b0),
                                                    random_word(wcode, 1'b0));
            while (pending_samples.size() > 6) @(posedge clock);
            hold_sender = 1'b1;
            while (expected_norms.size() > 0 || req_chan.valid) @(posedge clock);
            hold_sender = 1'b0;
         end
         for (int n = 0; n < 25; n++) begin
            a = random_word(wcode, kind == isn_pkg::KIND_IEEE && !be);
            b = random_word(wcode, kind == isn_pkg::KIND_IEEE && !be);
            add_sample(a, b);
         end
      end
      wait_drained();
      if (mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      wait (cycles >= 200000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
